### src/alle_pkg.sv
// ----------------------------------------------------------------------------
// alle_pkg
// Shared types and codes for the array linked list engine.
// ----------------------------------------------------------------------------
package alle_pkg;

  // operation codes
  localparam logic [2:0] FN_INS_BEFORE = 3'd0;
  localparam logic [2:0] FN_INS_AFTER  = 3'd1;
  localparam logic [2:0] FN_DELETE     = 3'd2;
  localparam logic [2:0] FN_FIND       = 3'd3;
  localparam logic [2:0] FN_COMPACT    = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SLOT = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BAD_LOG  = 2'd3;

  // stream field widths
  localparam int FUNC_W  = 3;
  localparam int POS_W   = 9;
  localparam int VAL_W   = 32;
  localparam int LIDX_W  = 9;
  localparam int IN_W    = 56;
  localparam int OUT_W   = 24;
  localparam int CFG_W   = 9;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_EVAL, S_INS1, S_INS2, S_DEL1, S_DEL2,
    S_FWALK, S_FSTEP, S_CWALK, S_CSTEP, S_CPRD, S_CPWR, S_FREE, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_SWEEP, OP_LOAD, OP_RD, OP_EVAL, OP_INS1, OP_INS2,
    OP_DEL1, OP_DEL2, OP_FWALK, OP_FSTEP, OP_CWALK, OP_CSTEP,
    OP_CPRD, OP_CPWR
  } dp_op_t;

  typedef enum logic [2:0] {
    GO_DONE, GO_INS, GO_DEL, GO_FIND, GO_COMP
  } go_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    go_t  go;
    logic find_end;
    logic cwalk_end;
    logic copy_end;
    logic skip_sweep;
    logic sweep_last;
  } dp_stat_t;

endpackage

### src/array_linked_list_engine.sv
// ----------------------------------------------------------------------------
// array_linked_list_engine
// Doubly linked list in slot memories with a free chain; one result per item.
// ----------------------------------------------------------------------------
// After reset a clearing pass over slots 0 to CAPACITY builds the free chain;
// no item is taken during it. Items then run one at a time through a
// controller that steps link memories with one read port, one write port and
// registered reads: insert and delete step through their link updates, find
// answers from the logical index when the list is compacted and otherwise
// walks the list hop by hop, and compact walks the list, copies it back and
// rebuilds the free chain. A finished result sits in an output register, so
// the next item is taken while it waits.
module array_linked_list_engine #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func[2:0], position[11:3], value[43:12], logical_index[52:44]
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], slot[10:2], element_count[19:11]
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  // capacity_in_use
  input  logic [8:0]  cfg_data
);
  import alle_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  alle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  alle_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_wdata (cfg_data),
    .out_data  (out_tdata)
  );

  // one item in flight: no second transfer right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  // failed operations report no slot
  a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != ST_OK) |-> (out_tdata[10:2] == 9'd0))
    else $error("failed operation reports a slot");

  // a result is loaded only from the controller's step that completes an item
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (cmd.op == OP_NONE))
    else $error("result loaded during a datapath step");

endmodule

### src/alle_dp.sv
// ----------------------------------------------------------------------------
// alle_dp
// Datapath: link, in-use, value and scratch memories plus list registers.
// ----------------------------------------------------------------------------
module alle_dp #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  alle_pkg::dp_cmd_t             cmd,
  output alle_pkg::dp_stat_t            stat,
  input  logic [alle_pkg::IN_W-1:0]     in_data,
  input  logic                          cfg_we,
  input  logic [alle_pkg::CFG_W-1:0]    cfg_wdata,
  output logic [alle_pkg::OUT_W-1:0]    out_data
);
  import alle_pkg::*;

  localparam int SW = $clog2(CAPACITY + 1);
  localparam int IW = SW + 1;
  localparam int CW = (IW > 9) ? IW : 9;

  // memories
  logic [SW-1:0]         next_mem [0:CAPACITY];
  logic [SW-1:0]         prev_mem [0:CAPACITY];
  logic                  use_mem  [0:CAPACITY];
  logic [VALUE_BITS-1:0] val_mem  [0:CAPACITY];
  logic [VALUE_BITS-1:0] scr_mem  [0:CAPACITY];

  logic [SW-1:0] nx_q, pv_q, nx_ra, pv_ra, us_ra, vl_ra, sc_ra;
  logic [SW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, us_wa, vl_wa, sc_wa;
  logic          us_q, nx_we, pv_we, us_we, us_wd, vl_we, sc_we;
  logic [VALUE_BITS-1:0] vl_q, sc_q, vl_wd, sc_wd;

  // registers
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [LIDX_W-1:0] k_r, k_nxt;
  logic [SW-1:0]     head_r, head_nxt, tail_r, tail_nxt, cnt_r, cnt_nxt;
  logic [SW-1:0]     free_r, free_nxt, n_r, n_nxt, s_r, s_nxt;
  logic [SW-1:0]     pn_r, pn_nxt, pp_r, pp_nxt, slot_r, slot_nxt;
  logic [IW-1:0]     i_r, i_nxt;
  logic              comp_r, comp_nxt;
  logic [CFG_W-1:0]  cap_r;
  logic [1:0]        st_r, st_nxt, ost_r;
  logic [POS_W-1:0]  oslot_r, ocnt_r;

  logic [SW-1:0] p_s, i_s;
  logic [CW-1:0] eff_cap;
  logic          pos_ok, live, bad, full, badlog;

  assign p_s = pos_ok ? SW'(pos_r) : '0;
  assign i_s = i_r[SW-1:0];
  assign pos_ok = (pos_r != '0) && (CW'(pos_r) <= CW'(CAPACITY));
  assign live = pos_ok && us_q;
  assign eff_cap = (cap_r == '0) ? CW'(1) :
                   ((CW'(cap_r) > CW'(CAPACITY)) ? CW'(CAPACITY) : CW'(cap_r));
  assign bad = (cnt_r == '0) ? (pos_r != '0) : !live;
  assign full = (CW'(cnt_r) >= eff_cap) || (free_r == '0);
  assign badlog = (k_r == '0) || (CW'(k_r) > CW'(cnt_r));

  // status to the controller
  always_comb begin
    stat.go = GO_DONE;
    case (func_r) inside
      FN_INS_BEFORE, FN_INS_AFTER: if (!bad && !full) stat.go = GO_INS;
      FN_DELETE:                   if (live) stat.go = GO_DEL;
      FN_FIND:                     if (!badlog && !comp_r) stat.go = GO_FIND;
      FN_COMPACT:                  if (!comp_r) stat.go = GO_COMP;
      default:                     stat.go = GO_DONE;
    endcase
    stat.find_end   = (CW'(i_r) >= CW'(k_r)) || (s_r == '0);
    stat.cwalk_end  = (s_r == '0) || (n_r >= cnt_r);
    stat.copy_end   = i_r > IW'(n_r);
    stat.skip_sweep = IW'(n_r) == IW'(CAPACITY);
    stat.sweep_last = i_r == IW'(CAPACITY);
  end

  // step logic
  always_comb begin
    func_nxt = func_r; pos_nxt = pos_r; val_nxt = val_r; k_nxt = k_r;
    head_nxt = head_r; tail_nxt = tail_r; cnt_nxt = cnt_r; free_nxt = free_r;
    n_nxt = n_r; s_nxt = s_r; pn_nxt = pn_r; pp_nxt = pp_r; slot_nxt = slot_r;
    i_nxt = i_r; comp_nxt = comp_r; st_nxt = st_r;
    nx_ra = '0; pv_ra = '0; us_ra = '0; vl_ra = '0; sc_ra = '0;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    us_we = 1'b0; us_wa = '0; us_wd = 1'b0;
    vl_we = 1'b0; vl_wa = '0; vl_wd = '0;
    sc_we = 1'b0; sc_wa = '0; sc_wd = '0;
    unique case (cmd.op)
      OP_NONE: ;
      // rebuild free chain entry, from reset or after compaction
      OP_SWEEP: begin
        nx_we = 1'b1; nx_wa = i_s;
        nx_wd = ((i_r != '0) && (i_r != IW'(CAPACITY))) ? SW'(i_r + 1'b1) : '0;
        pv_we = 1'b1; pv_wa = i_s;
        us_we = 1'b1; us_wa = i_s;
        i_nxt = i_r + 1'b1;
      end
      OP_LOAD: begin
        func_nxt = in_data[2:0];
        pos_nxt  = in_data[11:3];
        val_nxt  = in_data[43:12];
        k_nxt    = in_data[52:44];
      end
      OP_RD: begin
        nx_ra = p_s; pv_ra = p_s; us_ra = p_s;
      end
      // checks; fetch free head link for inserts
      OP_EVAL: begin
        nx_ra = free_r;
        pn_nxt = nx_q; pp_nxt = pv_q;
        n_nxt = free_r; slot_nxt = '0; st_nxt = ST_OK;
        case (func_r) inside
          FN_INS_BEFORE, FN_INS_AFTER:
            st_nxt = bad ? ST_BAD_SLOT : (full ? ST_FULL : ST_OK);
          FN_DELETE: if (!live) st_nxt = ST_BAD_SLOT;
          FN_FIND: begin
            if (badlog) st_nxt = ST_BAD_LOG;
            else if (comp_r) slot_nxt = SW'(k_r);
            s_nxt = head_r; i_nxt = IW'(1);
          end
          FN_COMPACT: begin
            s_nxt = head_r; n_nxt = '0;
          end
          default: ;
        endcase
      end
      // new slot: own links, head/tail
      OP_INS1: begin
        free_nxt = nx_q;
        vl_we = 1'b1; vl_wa = n_r; vl_wd = VALUE_BITS'(val_r);
        us_we = 1'b1; us_wa = n_r; us_wd = 1'b1;
        nx_we = 1'b1; nx_wa = n_r; pv_we = 1'b1; pv_wa = n_r;
        if (cnt_r == '0) begin
          head_nxt = n_r; tail_nxt = n_r;
        end else if (func_r == FN_INS_AFTER) begin
          pv_wd = p_s; nx_wd = pn_r;
          if (p_s == tail_r) tail_nxt = n_r;
          else comp_nxt = 1'b0;
        end else begin
          nx_wd = p_s; pv_wd = pp_r;
          if (p_s == head_r) head_nxt = n_r;
          comp_nxt = 1'b0;
        end
      end
      // neighbor links
      OP_INS2: begin
        if (cnt_r != '0) begin
          if (func_r == FN_INS_AFTER) begin
            pv_we = (pn_r != '0); pv_wa = pn_r; pv_wd = n_r;
            nx_we = 1'b1; nx_wa = p_s; nx_wd = n_r;
          end else begin
            nx_we = (pp_r != '0); nx_wa = pp_r; nx_wd = n_r;
            pv_we = 1'b1; pv_wa = p_s; pv_wd = n_r;
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        slot_nxt = n_r;
      end
      // unlink from neighbors
      OP_DEL1: begin
        if (cnt_r <= SW'(1)) begin
          head_nxt = '0; tail_nxt = '0; comp_nxt = 1'b0;
        end else if (p_s == head_r) begin
          head_nxt = pn_r; comp_nxt = 1'b0;
          pv_we = 1'b1; pv_wa = pn_r;
        end else if (p_s == tail_r) begin
          tail_nxt = pp_r;
          nx_we = 1'b1; nx_wa = pp_r;
        end else begin
          nx_we = 1'b1; nx_wa = pp_r; nx_wd = pn_r;
          pv_we = 1'b1; pv_wa = pn_r; pv_wd = pp_r;
          comp_nxt = 1'b0;
        end
      end
      // return slot to free chain
      OP_DEL2: begin
        us_we = 1'b1; us_wa = p_s;
        pv_we = 1'b1; pv_wa = p_s;
        nx_we = 1'b1; nx_wa = p_s; nx_wd = free_r;
        free_nxt = p_s;
        if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
      end
      OP_FWALK: begin
        nx_ra = s_r;
        if (stat.find_end) slot_nxt = s_r;
      end
      OP_FSTEP: begin
        s_nxt = nx_q; i_nxt = i_r + 1'b1;
      end
      OP_CWALK: begin
        nx_ra = s_r; vl_ra = s_r;
        if (stat.cwalk_end) i_nxt = IW'(1);
      end
      OP_CSTEP: begin
        sc_we = 1'b1; sc_wa = n_r + 1'b1; sc_wd = vl_q;
        n_nxt = n_r + 1'b1; s_nxt = nx_q;
      end
      // copy back; at the end commit list registers and start free sweep unless the list fills all slots
      OP_CPRD: begin
        sc_ra = i_s;
        if (stat.copy_end) begin
          cnt_nxt = n_r; tail_nxt = n_r;
          head_nxt = (n_r != '0) ? SW'(1) : '0;
          comp_nxt = 1'b1;
          i_nxt = IW'(n_r) + 1'b1;
          free_nxt = stat.skip_sweep ? '0 : SW'(IW'(n_r) + 1'b1);
        end
      end
      OP_CPWR: begin
        vl_we = 1'b1; vl_wa = i_s; vl_wd = sc_q;
        us_we = 1'b1; us_wa = i_s; us_wd = 1'b1;
        pv_we = 1'b1; pv_wa = i_s; pv_wd = SW'(i_r - 1'b1);
        nx_we = 1'b1; nx_wa = i_s;
        nx_wd = (i_r < IW'(n_r)) ? SW'(i_r + 1'b1) : '0;
        i_nxt = i_r + 1'b1;
      end
      default: ;
    endcase
  end

  // memories, registered reads
  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    nx_q <= next_mem[nx_ra];
  end
  always_ff @(posedge clk) begin
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    pv_q <= prev_mem[pv_ra];
  end
  always_ff @(posedge clk) begin
    if (us_we) use_mem[us_wa] <= us_wd;
    us_q <= use_mem[us_ra];
  end
  always_ff @(posedge clk) begin
    if (vl_we) val_mem[vl_wa] <= vl_wd;
    vl_q <= val_mem[vl_ra];
  end
  always_ff @(posedge clk) begin
    if (sc_we) scr_mem[sc_wa] <= sc_wd;
    sc_q <= scr_mem[sc_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0; tail_r <= '0; cnt_r <= '0; free_r <= SW'(1);
      comp_r <= 1'b0; i_r <= '0;
      cap_r  <= CFG_W'((CAPACITY > 511) ? 511 : CAPACITY);
    end else begin
      head_r <= head_nxt; tail_r <= tail_nxt; cnt_r <= cnt_nxt;
      free_r <= free_nxt; comp_r <= comp_nxt; i_r <= i_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r <= func_nxt; pos_r <= pos_nxt; val_r <= val_nxt; k_r <= k_nxt;
    n_r <= n_nxt; s_r <= s_nxt; pn_r <= pn_nxt; pp_r <= pp_nxt;
    slot_r <= slot_nxt; st_r <= st_nxt;
    if (cmd.load_out) begin
      ost_r   <= st_r;
      oslot_r <= POS_W'(slot_r);
      ocnt_r  <= POS_W'(cnt_r);
    end
  end

  assign out_data = {4'b0, ocnt_r, oslot_r, ost_r};

endmodule

### src/alle_ctrl.sv
// ----------------------------------------------------------------------------
// alle_ctrl
// Controller: sequences datapath steps and owns the stream handshakes.
// ----------------------------------------------------------------------------
module alle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output alle_pkg::dp_cmd_t  cmd,
  input  alle_pkg::dp_stat_t stat
);
  import alle_pkg::*;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // next state and step commands
  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.load_out = 1'b0;
    in_ready     = 1'b0;
    ov_nxt       = ov_r && !out_ready;
    unique case (state_r)
      S_CLR: begin
        cmd.op = OP_SWEEP;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.op = OP_RD;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.op = OP_EVAL;
        unique case (stat.go)
          GO_INS:  state_nxt = S_INS1;
          GO_DEL:  state_nxt = S_DEL1;
          GO_FIND: state_nxt = S_FWALK;
          GO_COMP: state_nxt = S_CWALK;
          default: state_nxt = S_DONE;
        endcase
      end
      S_INS1: begin cmd.op = OP_INS1; state_nxt = S_INS2; end
      S_INS2: begin cmd.op = OP_INS2; state_nxt = S_DONE; end
      S_DEL1: begin cmd.op = OP_DEL1; state_nxt = S_DEL2; end
      S_DEL2: begin cmd.op = OP_DEL2; state_nxt = S_DONE; end
      S_FWALK: begin
        cmd.op = OP_FWALK;
        state_nxt = stat.find_end ? S_DONE : S_FSTEP;
      end
      S_FSTEP: begin cmd.op = OP_FSTEP; state_nxt = S_FWALK; end
      S_CWALK: begin
        cmd.op = OP_CWALK;
        state_nxt = stat.cwalk_end ? S_CPRD : S_CSTEP;
      end
      S_CSTEP: begin cmd.op = OP_CSTEP; state_nxt = S_CWALK; end
      S_CPRD: begin
        cmd.op = OP_CPRD;
        if (!stat.copy_end) state_nxt = S_CPWR;
        else if (stat.skip_sweep) state_nxt = S_DONE;
        else state_nxt = S_FREE;
      end
      S_CPWR: begin cmd.op = OP_CPWR; state_nxt = S_CPRD; end
      S_FREE: begin
        cmd.op = OP_SWEEP;
        if (stat.sweep_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.load_out = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = ov_r;

endmodule
